>>> rtl/lfpd_pkg.sv
package lfpd_pkg;

    // Field widths.
    localparam int PAT_W   = 5;
    localparam int E_W     = 9;
    localparam int GAIN_W  = 12;
    localparam int SUM_W   = 20;
    localparam int DE_W    = E_W + 1;
    localparam int PP_W    = GAIN_W + 1 + E_W;
    localparam int PI_W    = GAIN_W + 1 + SUM_W;
    localparam int PD_W    = GAIN_W + 1 + DE_W;
    localparam int ADJ_W   = PI_W + 1;
    localparam int FRAC_W  = 8;
    localparam int TRUNC_W = ADJ_W - FRAC_W;
    localparam int SPD_W   = TRUNC_W + 1;
    localparam int OUT_W   = 8;
    localparam int BASE_W  = 6;

    // APB register map.
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    typedef enum logic [1:0] {
        REG_GAIN_PROP  = 2'd0,
        REG_GAIN_INTEG = 2'd1,
        REG_GAIN_DERIV = 2'd2
    } t_reg_idx;

    localparam logic [GAIN_W-1:0] GAIN_PROP_RST  = 12'd240;
    localparam logic [GAIN_W-1:0] GAIN_INTEG_RST = 12'd0;
    localparam logic [GAIN_W-1:0] GAIN_DERIV_RST = 12'd80;

    // Sensor and offset thresholds, offsets in Q5.4.
    localparam logic [PAT_W-1:0] LOST_PATTERN = 5'h1F;
    localparam int Q_TWO     = 32;
    localparam int Q_FOUR    = 64;
    localparam int Q_FIVE    = 80;
    localparam int SUM_LIMIT = 524287;

    // Speeds in signed percent.
    localparam int DEAD_MIN  = 35;
    localparam int SPEED_MAX = 100;
    localparam logic [BASE_W-1:0] BASE_NEAR = 6'd40;
    localparam logic [BASE_W-1:0] BASE_FAR  = 6'd35;
    localparam logic signed [OUT_W-1:0] SPD_SPIN     = 8'sd70;
    localparam logic signed [OUT_W-1:0] SPD_CREEP    = 8'sd35;
    localparam logic signed [OUT_W-1:0] SPD_HARD_FWD = 8'sd80;
    localparam logic signed [OUT_W-1:0] SPD_HARD_REV = -8'sd50;

    // Operands of the PID products.
    typedef struct packed {
        logic signed [E_W-1:0]   e;
        logic signed [SUM_W-1:0] sum;
        logic signed [DE_W-1:0]  de;
    } t_pid_terms;

    // Registered PID products.
    typedef struct packed {
        logic signed [PP_W-1:0] pp;
        logic signed [PI_W-1:0] pi;
        logic signed [PD_W-1:0] pd;
    } t_pid_prod;

    // Deadzone followed by the clamp to the legal speed range.
    function automatic logic signed [OUT_W-1:0] shape_speed(
        input logic signed [SPD_W-1:0] v
    );
        logic signed [SPD_W-1:0] d;
        if (v > 0 && v < DEAD_MIN) begin
            d = SPD_W'(DEAD_MIN);
        end else if (v < 0 && v > -DEAD_MIN) begin
            d = -SPD_W'(DEAD_MIN);
        end else begin
            d = v;
        end
        if (d > SPEED_MAX) begin
            d = SPD_W'(SPEED_MAX);
        end else if (d < -SPEED_MAX) begin
            d = -SPD_W'(SPEED_MAX);
        end
        return d[OUT_W-1:0];
    endfunction

endpackage

>>> rtl/lfpd_mult.sv
module lfpd_mult
    import lfpd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_en,
    input  t_pid_terms               i_terms,
    input  logic [GAIN_W-1:0]        i_gain_prop,
    input  logic [GAIN_W-1:0]        i_gain_integ,
    input  logic [GAIN_W-1:0]        i_gain_deriv,
    output t_pid_prod                o_prod
);

    // Gains are unsigned, so each gets a zero sign bit before the signed multiply.
    logic signed [PP_W-1:0] n_pp;
    logic signed [PI_W-1:0] n_pi;
    logic signed [PD_W-1:0] n_pd;
    t_pid_prod              r_prod;

    assign n_pp = PP_W'($signed({1'b0, i_gain_prop}))  * PP_W'(i_terms.e);
    assign n_pi = PI_W'($signed({1'b0, i_gain_integ})) * PI_W'(i_terms.sum);
    assign n_pd = PD_W'($signed({1'b0, i_gain_deriv})) * PD_W'(i_terms.de);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod.pp <= n_pp;
            r_prod.pi <= n_pi;
            r_prod.pd <= n_pd;
        end
    end

    assign o_prod = r_prod;

endmodule

>>> rtl/line_follow_pid_drive.sv
// Line-following PID drive. Each accepted item carries a 5-bit sensor pattern and the
// current and previous line offsets in signed Q5.4; each item produces exactly one result
// item with left and right wheel speeds in signed percent (-100..100). An all-ones pattern
// means the line is lost: fixed spin or creep speeds are chosen from the previous offset
// and the PID state is untouched. Otherwise a PID step with unsigned Q8.4 gains runs on
// the current offset (integral saturating at +/-(2^19-1), history cleared when the line
// comes back), the truncated adjustment is added to the left base speed and subtracted
// from the right, and a deadzone, a clamp and the hard-turn overrides follow.
// The block takes one item every cycle while the output does not stall; an accepted
// item passes the input register, the state update, the multipliers and the adjustment
// sum before it lands in the result register. The loop that sets the rate is the
// integral and previous-error update in the state stage. Gains must be written over APB
// at byte addresses 0, 4 and 8 only while no item is in flight; the block itself does
// not enforce this. pready is tied high.
module line_follow_pid_drive
    import lfpd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready,

    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [PAT_W-1:0]         i_line_pattern,
    input  logic signed [E_W-1:0]    i_offset_now,
    input  logic signed [E_W-1:0]    i_offset_before,

    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [OUT_W-1:0]  o_speed_left,
    output logic signed [OUT_W-1:0]  o_speed_right
);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [GAIN_W-1:0] r_gain_prop;
    logic [GAIN_W-1:0] r_gain_integ;
    logic [GAIN_W-1:0] r_gain_deriv;
    t_reg_idx          cfg_idx;
    logic              cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_prop  <= GAIN_PROP_RST;
            r_gain_integ <= GAIN_INTEG_RST;
            r_gain_deriv <= GAIN_DERIV_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_GAIN_PROP:  r_gain_prop  <= pwdata[GAIN_W-1:0];
                REG_GAIN_INTEG: r_gain_integ <= pwdata[GAIN_W-1:0];
                REG_GAIN_DERIV: r_gain_deriv <= pwdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_GAIN_PROP:  prdata = DATA_W'(r_gain_prop);
            REG_GAIN_INTEG: prdata = DATA_W'(r_gain_integ);
            REG_GAIN_DERIV: prdata = DATA_W'(r_gain_deriv);
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. Each stage loads when it is empty or when the stage after
    // it loads, so a bubble anywhere can be filled while the result register waits.
    // ------------------------------------------------------------------
    logic r_s0_valid, r_s1_valid, r_s2_valid, r_s3_valid, r_out_valid;
    logic en0, en1, en2, en3, en4;

    assign en4 = !r_out_valid || !i_out_stall;
    assign en3 = !r_s3_valid  || en4;
    assign en2 = !r_s2_valid  || en3;
    assign en1 = !r_s1_valid  || en2;
    assign en0 = !r_s0_valid  || en1;

    assign o_in_stall  = !en0;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid  <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en0) r_s0_valid  <= i_in_valid;
            if (en1) r_s1_valid  <= r_s0_valid;
            if (en2) r_s2_valid  <= r_s1_valid;
            if (en3) r_s3_valid  <= r_s2_valid;
            if (en4) r_out_valid <= r_s3_valid;
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: input register.
    // ------------------------------------------------------------------
    logic [PAT_W-1:0]      r_s0_pattern;
    logic signed [E_W-1:0] r_s0_e;
    logic signed [E_W-1:0] r_s0_eb;

    always_ff @(posedge i_clk) begin
        if (en0) begin
            r_s0_pattern <= i_line_pattern;
            r_s0_e       <= i_offset_now;
            r_s0_eb      <= i_offset_before;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: PID state update. The integral and the previous error live here, so
    // back-to-back items see each other's updates without any forwarding.
    // ------------------------------------------------------------------
    logic signed [E_W-1:0]   r_prior_error;
    logic signed [SUM_W-1:0] r_error_sum;
    logic                    r_was_lost;

    logic                    s1_fire;
    logic                    s1_lost;
    logic signed [E_W-1:0]   prior_eff;
    logic signed [SUM_W-1:0] sum_base;
    logic signed [SUM_W:0]   sum_raw;
    logic signed [SUM_W-1:0] sum_sat;
    logic signed [DE_W-1:0]  de;

    logic                    n_fix;
    logic signed [OUT_W-1:0] n_fix_left;
    logic signed [OUT_W-1:0] n_fix_right;
    logic [BASE_W-1:0]       n_base;

    assign s1_fire = r_s0_valid && en1;
    assign s1_lost = (r_s0_pattern == LOST_PATTERN);

    // Coming back from a lost line restarts the integral and zeroes the derivative.
    assign prior_eff = r_was_lost ? r_s0_e : r_prior_error;
    assign sum_base  = r_was_lost ? '0 : r_error_sum;
    assign sum_raw   = (SUM_W+1)'(sum_base) + (SUM_W+1)'(r_s0_e);
    assign de        = DE_W'(r_s0_e) - DE_W'(prior_eff);

    always_comb begin
        if (sum_raw > SUM_LIMIT) begin
            sum_sat = SUM_W'(SUM_LIMIT);
        end else if (sum_raw < -SUM_LIMIT) begin
            sum_sat = -SUM_W'(SUM_LIMIT);
        end else begin
            sum_sat = sum_raw[SUM_W-1:0];
        end
    end

    // Fixed speed pairs: recovery while lost, and the hard-turn overrides.
    always_comb begin
        n_fix       = 1'b0;
        n_fix_left  = SPD_CREEP;
        n_fix_right = SPD_CREEP;
        if (s1_lost) begin
            n_fix = 1'b1;
            if (r_s0_eb > Q_TWO) begin
                n_fix_left  = SPD_SPIN;
                n_fix_right = -SPD_SPIN;
            end else if (r_s0_eb < -Q_TWO) begin
                n_fix_left  = -SPD_SPIN;
                n_fix_right = SPD_SPIN;
            end
        end else if (r_s0_e <= -Q_FOUR) begin
            n_fix       = 1'b1;
            n_fix_left  = SPD_HARD_REV;
            n_fix_right = SPD_HARD_FWD;
        end else if (r_s0_e >= Q_FOUR && r_s0_e <= Q_FIVE) begin
            n_fix       = 1'b1;
            n_fix_left  = SPD_HARD_FWD;
            n_fix_right = SPD_HARD_REV;
        end
    end

    assign n_base = (r_s0_e >= Q_TWO || r_s0_e <= -Q_TWO) ? BASE_FAR : BASE_NEAR;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prior_error <= '0;
            r_error_sum   <= '0;
            r_was_lost    <= 1'b0;
        end else if (s1_fire) begin
            r_was_lost <= s1_lost;
            if (!s1_lost) begin
                r_prior_error <= r_s0_e;
                r_error_sum   <= sum_sat;
            end
        end
    end

    t_pid_terms              r_s1_terms;
    logic                    r_s1_fix;
    logic signed [OUT_W-1:0] r_s1_fix_left;
    logic signed [OUT_W-1:0] r_s1_fix_right;
    logic [BASE_W-1:0]       r_s1_base;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_terms.e   <= r_s0_e;
            r_s1_terms.sum <= sum_sat;
            r_s1_terms.de  <= de;
            r_s1_fix       <= n_fix;
            r_s1_fix_left  <= n_fix_left;
            r_s1_fix_right <= n_fix_right;
            r_s1_base      <= n_base;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: the three gain products.
    // ------------------------------------------------------------------
    t_pid_prod               s2_prod;
    logic                    r_s2_fix;
    logic signed [OUT_W-1:0] r_s2_fix_left;
    logic signed [OUT_W-1:0] r_s2_fix_right;
    logic [BASE_W-1:0]       r_s2_base;

    lfpd_mult u_mult (
        .i_clk        (i_clk),
        .i_en         (en2),
        .i_terms      (r_s1_terms),
        .i_gain_prop  (r_gain_prop),
        .i_gain_integ (r_gain_integ),
        .i_gain_deriv (r_gain_deriv),
        .o_prod       (s2_prod)
    );

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_fix       <= r_s1_fix;
            r_s2_fix_left  <= r_s1_fix_left;
            r_s2_fix_right <= r_s1_fix_right;
            r_s2_base      <= r_s1_base;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: sum the products (Q.8) and truncate toward zero to whole percent.
    // Negative sums get a bias of one less than the divisor before the shift.
    // ------------------------------------------------------------------
    logic signed [ADJ_W-1:0]   adj;
    logic signed [ADJ_W-1:0]   adj_biased;
    logic signed [TRUNC_W-1:0] r_s3_trunc;
    logic                      r_s3_fix;
    logic signed [OUT_W-1:0]   r_s3_fix_left;
    logic signed [OUT_W-1:0]   r_s3_fix_right;
    logic [BASE_W-1:0]         r_s3_base;

    assign adj = ADJ_W'(s2_prod.pp) + ADJ_W'(s2_prod.pi) + ADJ_W'(s2_prod.pd);
    assign adj_biased = adj[ADJ_W-1] ? adj + ADJ_W'((1 << FRAC_W) - 1) : adj;

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_trunc     <= adj_biased[ADJ_W-1:FRAC_W];
            r_s3_fix       <= r_s2_fix;
            r_s3_fix_left  <= r_s2_fix_left;
            r_s3_fix_right <= r_s2_fix_right;
            r_s3_base      <= r_s2_base;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: wheel speeds, deadzone and clamp, then the fixed overrides.
    // ------------------------------------------------------------------
    logic signed [SPD_W-1:0] base_ext;
    logic signed [SPD_W-1:0] raw_left;
    logic signed [SPD_W-1:0] raw_right;
    logic signed [OUT_W-1:0] n_speed_left;
    logic signed [OUT_W-1:0] n_speed_right;
    logic signed [OUT_W-1:0] r_speed_left;
    logic signed [OUT_W-1:0] r_speed_right;

    assign base_ext  = SPD_W'($signed({1'b0, r_s3_base}));
    assign raw_left  = base_ext + SPD_W'(r_s3_trunc);
    assign raw_right = base_ext - SPD_W'(r_s3_trunc);

    assign n_speed_left  = r_s3_fix ? r_s3_fix_left  : shape_speed(raw_left);
    assign n_speed_right = r_s3_fix ? r_s3_fix_right : shape_speed(raw_right);

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_speed_left  <= n_speed_left;
            r_speed_right <= n_speed_right;
        end
    end

    assign o_speed_left  = r_speed_left;
    assign o_speed_right = r_speed_right;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // Every delivered speed lies in the legal command range.
    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_speed_left >= -SPEED_MAX && o_speed_left <= SPEED_MAX &&
                         o_speed_right >= -SPEED_MAX && o_speed_right <= SPEED_MAX))
        else $error("speed command out of range");

    // A lost-line item leaves the PID history untouched and marks the line as lost.
    a_lost_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && s1_lost) |=>
            ($stable(r_error_sum) && $stable(r_prior_error) && r_was_lost))
        else $error("lost item disturbed PID state");

    // The integral never falls below the lower end of its saturation window.
    a_sum_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_error_sum >= -SUM_LIMIT))
        else $error("integral below saturation limit");

    // An item following a lost one starts with a zero derivative.
    a_regain_de: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && !s1_lost && r_was_lost) |=> (r_s1_terms.de == '0))
        else $error("derivative not cleared on line regain");

endmodule

>>> tb/line_follow_pid_drive_test.sv
module line_follow_pid_drive_test
    import lfpd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Depth of the pipeline from a taken item to its result. The drain waits past it
    // before any gain is written.
    localparam int PIPE_LATENCY = 4;
    // The receiver holds off this long once per request. That is far longer than the
    // pipeline is deep, so the input side has to stall while items are still offered.
    localparam int HOLD_CYCLES  = 150;
    // The watchdog fires after this many cycles in which neither side moves an item.
    localparam int IDLE_LIMIT   = 1000;

    // Offsets that sit on or next to a threshold of the controller: the base speed
    // step at +-2.0, the hard turns at -4.0 and 4.0..5.0, and both ends of the range.
    localparam int OFFSET_MARKS [16] = '{-256, -255, -65, -64, -63, -33, -32, -31,
                                         31, 32, 33, 63, 64, 80, 81, 255};

    typedef struct {
        logic [PAT_W-1:0]      pattern;
        logic signed [E_W-1:0] now;
        logic signed [E_W-1:0] prev;
    } t_sensor_item;

    typedef struct {
        logic signed [OUT_W-1:0] left;
        logic signed [OUT_W-1:0] right;
    } t_wheel_speeds;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;

    // Tracks the controller state and the gains on the testbench side, works out the
    // wheel speeds for every item the block takes, and checks the block's results
    // against them in order.
    class t_wheel_speed_tracker;
        logic [GAIN_W-1:0]       gain_p;
        logic [GAIN_W-1:0]       gain_i;
        logic [GAIN_W-1:0]       gain_d;
        logic signed [E_W-1:0]   last_err;
        logic signed [SUM_W-1:0] err_sum;
        bit                      line_was_lost;
        t_wheel_speeds           expected_speeds [$];
        int unsigned             mismatches;

        function new();
            gain_p        = GAIN_PROP_RST;
            gain_i        = GAIN_INTEG_RST;
            gain_d        = GAIN_DERIV_RST;
            last_err      = '0;
            err_sum       = '0;
            line_was_lost = 1'b0;
            mismatches    = 0;
        endfunction

        function void set_gain(t_reg_idx idx, logic [GAIN_W-1:0] val);
            case (idx)
                REG_GAIN_PROP:  gain_p = val;
                REG_GAIN_INTEG: gain_i = val;
                REG_GAIN_DERIV: gain_d = val;
                default: ;
            endcase
        endfunction

        // Deadzone first, then the clamp to the legal speed range.
        function longint shape(longint s);
            if (s > 0 && s < DEAD_MIN) begin
                s = DEAD_MIN;
            end else if (s < 0 && s > -DEAD_MIN) begin
                s = -DEAD_MIN;
            end
            if (s > SPEED_MAX) begin
                s = SPEED_MAX;
            end else if (s < -SPEED_MAX) begin
                s = -SPEED_MAX;
            end
            return s;
        endfunction

        function void note_item(t_sensor_item it);
            longint        e;
            longint        sum;
            longint        adj;
            longint        trunc;
            longint        base;
            longint        lspd;
            longint        rspd;
            t_wheel_speeds w;
            e = it.now;
            if (it.pattern == LOST_PATTERN) begin
                // Line lost: recovery speeds from the previous offset, PID state kept.
                if (it.prev > Q_TWO) begin
                    lspd = SPD_SPIN;
                    rspd = -SPD_SPIN;
                end else if (it.prev < -Q_TWO) begin
                    lspd = -SPD_SPIN;
                    rspd = SPD_SPIN;
                end else begin
                    lspd = SPD_CREEP;
                    rspd = SPD_CREEP;
                end
                line_was_lost = 1'b1;
            end else begin
                // On the first tick after the line comes back the history restarts,
                // so the derivative term is zero and the integral starts from nothing.
                if (line_was_lost) begin
                    last_err = it.now;
                    err_sum  = '0;
                end
                base = (e >= Q_TWO || e <= -Q_TWO) ? BASE_FAR : BASE_NEAR;
                sum = longint'(err_sum) + e;
                if (sum > SUM_LIMIT) begin
                    sum = SUM_LIMIT;
                end else if (sum < -SUM_LIMIT) begin
                    sum = -SUM_LIMIT;
                end
                err_sum = SUM_W'(sum);
                adj = longint'(gain_p) * e + longint'(gain_i) * sum
                    + longint'(gain_d) * (e - longint'(last_err));
                last_err = it.now;
                // Gains and offsets are both Q.4, so the product is Q.8; division
                // truncates toward zero.
                trunc = adj / 256;
                lspd = shape(base + trunc);
                rspd = shape(base - trunc);
                if (e <= -Q_FOUR) begin
                    lspd = SPD_HARD_REV;
                    rspd = SPD_HARD_FWD;
                end
                if (e >= Q_FOUR && e <= Q_FIVE) begin
                    lspd = SPD_HARD_FWD;
                    rspd = SPD_HARD_REV;
                end
                line_was_lost = 1'b0;
            end
            w.left  = OUT_W'(lspd);
            w.right = OUT_W'(rspd);
            expected_speeds.push_back(w);
        endfunction

        function void check_speeds(logic signed [OUT_W-1:0] got_left,
                                   logic signed [OUT_W-1:0] got_right);
            t_wheel_speeds w;
            if (expected_speeds.size() == 0) begin
                $display("%0t: result (%0d, %0d) arrived with nothing expected",
                         $time, got_left, got_right);
                mismatches++;
            end else begin
                w = expected_speeds.pop_front();
                if (got_left !== w.left) begin
                    $display("%0t: speed_left expected %0d, actual %0d",
                             $time, w.left, got_left);
                    mismatches++;
                end
                if (got_right !== w.right) begin
                    $display("%0t: speed_right expected %0d, actual %0d",
                             $time, w.right, got_right);
                    mismatches++;
                end
            end
        endfunction
    endclass

    // Every input of the block starts at a known value; reset is held low from time 0.
    logic                    i_clk           = 1'b0;
    logic                    i_rst_n         = 1'b0;
    logic                    psel            = 1'b0;
    logic                    penable         = 1'b0;
    logic                    pwrite          = 1'b0;
    logic [ADDR_W-1:0]       paddr           = '0;
    logic [DATA_W-1:0]       pwdata          = '0;
    logic [DATA_W-1:0]       prdata;
    logic                    pready;
    logic                    i_in_valid      = 1'b0;
    logic                    o_in_stall;
    logic [PAT_W-1:0]        i_line_pattern  = '0;
    logic signed [E_W-1:0]   i_offset_now    = '0;
    logic signed [E_W-1:0]   i_offset_before = '0;
    logic                    o_out_valid;
    logic                    i_out_stall     = 1'b0;
    logic signed [OUT_W-1:0] o_speed_left;
    logic signed [OUT_W-1:0] o_speed_right;

    t_wheel_speed_tracker speeds = new();

    // Set by the stimulus, cleared by the receiver when it starts its long hold-off.
    bit hold_off_req = 1'b0;
    // Items left in the sender's current burst.
    int burst_left   = 0;
    int idle_cycles  = 0;

    line_follow_pid_drive dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_line_pattern  (i_line_pattern),
        .i_offset_now    (i_offset_now),
        .i_offset_before (i_offset_before),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_speed_left    (o_speed_left),
        .o_speed_right   (o_speed_right)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // All sampling happens at the rising edge, before the nonblocking updates of that
    // edge land, so both the block and the testbench see the values from before it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            speeds.check_speeds(o_speed_left, o_speed_right);
        end
    end

    // Watchdog: a run that stops moving items for too long has hung.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no item moved for %0d cycles, %0d results still expected",
                     $time, IDLE_LIMIT, speeds.expected_speeds.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // The receiver switches between stall patterns in segments of random length:
    // no stall at all, light or heavy random stalls, and a fixed duty cycle. When the
    // stimulus asks, it holds off for a long stretch that it counts itself.
    initial begin : out_stall_pattern
        int          seg_len;
        int          period;
        int          duty;
        t_stall_mode mode;
        forever begin
            seg_len = $urandom_range(10, 200);
            mode    = t_stall_mode'($urandom_range(0, 3));
            period  = $urandom_range(2, 7);
            duty    = $urandom_range(1, period - 1);
            for (int c = 0; c < seg_len; c++) begin
                @(posedge i_clk);
                if (hold_off_req) begin
                    hold_off_req = 1'b0;
                    i_out_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                    i_out_stall <= 1'b0;
                end else begin
                    case (mode)
                        STALL_NONE:  i_out_stall <= 1'b0;
                        STALL_LIGHT: i_out_stall <= ($urandom_range(0, 99) < 25);
                        STALL_HEAVY: i_out_stall <= ($urandom_range(0, 99) < 65);
                        default:     i_out_stall <= ((c % period) < duty);
                    endcase
                end
            end
        end
    end

    // Between bursts the sender drops valid for a random pause. Some bursts are long, so
    // there are stretches where the input side never idles.
    task automatic pace_sender();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 15);
        end
    endtask

    // Offers one item and holds it until the block takes it. Valid stays high into the
    // next item unless the sender decides to pause.
    task automatic send_item(logic [PAT_W-1:0] pat, logic signed [E_W-1:0] now,
                             logic signed [E_W-1:0] prev);
        t_sensor_item it;
        it.pattern = pat;
        it.now     = now;
        it.prev    = prev;
        i_in_valid      <= 1'b1;
        i_line_pattern  <= pat;
        i_offset_now    <= now;
        i_offset_before <= prev;
        do @(posedge i_clk); while (o_in_stall);
        speeds.note_item(it);
        pace_sender();
    endtask

    // Stops sending and waits until every expected result has come back, then waits past
    // the pipeline depth as well so that nothing is left inside the block.
    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        while (speeds.expected_speeds.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 3) @(posedge i_clk);
    endtask

    // One APB write, directly followed by a read of the same register to check it.
    task automatic write_gain(t_reg_idx idx, logic [GAIN_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * int'(idx));
        pwdata  <= DATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        speeds.set_gain(idx, val);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== DATA_W'(val)) begin
            $display("%0t: gain register %s read back expected %0d, actual %0d",
                     $time, idx.name(), val, prdata);
            speeds.mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_gains(logic [GAIN_W-1:0] kp, logic [GAIN_W-1:0] ki,
                             logic [GAIN_W-1:0] kd);
        write_gain(REG_GAIN_PROP, kp);
        write_gain(REG_GAIN_INTEG, ki);
        write_gain(REG_GAIN_DERIV, kd);
    endtask

    // Offsets are drawn mostly near zero and on the thresholds, so that the deadzone,
    // the base speed step and the hard turns are all hit often, with some full-range
    // values mixed in.
    function automatic logic signed [E_W-1:0] pick_offset();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 35) begin
            return E_W'($urandom_range(0, 160) - 80);
        end else if (sel < 55) begin
            return E_W'(OFFSET_MARKS[$urandom_range(0, 15)]);
        end else if (sel < 70) begin
            return E_W'($urandom_range(0, 20) - 10);
        end
        return E_W'($urandom);
    endfunction

    // About one item in seven has the line lost, so lost ticks, the first tick back on
    // the line and runs of ordinary ticks all occur.
    task automatic run_random(int count);
        logic [PAT_W-1:0]      pat;
        logic signed [E_W-1:0] prev;
        repeat (count) begin
            pat  = ($urandom_range(0, 99) < 14) ? LOST_PATTERN
                                                : PAT_W'($urandom_range(0, 30));
            prev = ($urandom_range(0, 1) == 0) ? E_W'(OFFSET_MARKS[$urandom_range(3, 12)])
                                               : E_W'($urandom);
            send_item(pat, pick_offset(), prev);
        end
    endtask

    // A run of tracking ticks with offsets in lo..hi. The pattern never reads as lost,
    // so the integral keeps building up across the run.
    task automatic run_offset_span(int count, int lo, int hi);
        repeat (count) begin
            send_item(PAT_W'($urandom_range(0, 30)), E_W'(lo + $urandom_range(0, hi - lo)),
                      E_W'($urandom));
        end
    endtask

    initial begin : stimulus
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items at the reset gains: field extremes, the threshold offsets,
        // every kind of lost tick and the first tick after the line comes back.
        send_item(5'h00, 0, 0);
        send_item(5'h04, 1, 0);
        send_item(5'h0E, 255, -256);
        send_item(5'h1E, -256, 255);
        send_item(5'h01, 64, 0);
        send_item(5'h03, 80, 0);
        send_item(5'h06, 81, 0);
        send_item(5'h0C, 63, 0);
        send_item(5'h18, -64, 0);
        send_item(5'h10, -63, 0);
        send_item(5'h08, 32, 0);
        send_item(5'h02, 31, 0);
        send_item(5'h11, -32, 0);
        send_item(5'h19, -31, 0);
        send_item(LOST_PATTERN, 10, 33);
        send_item(LOST_PATTERN, -10, 32);
        send_item(LOST_PATTERN, 255, -33);
        send_item(LOST_PATTERN, -256, -32);
        send_item(LOST_PATTERN, 0, 255);
        send_item(LOST_PATTERN, 0, -256);
        send_item(5'h04, 100, 0);
        send_item(5'h04, -2, 0);
        send_item(5'h0F, 0, 0);
        run_random(100);
        wait_all_results();

        // Smallest gains: only the base speed is left. The receiver holds off for a
        // long time here, so the block fills up and stalls its input.
        set_gains(12'd0, 12'd0, 12'd0);
        hold_off_req = 1'b1;
        run_random(100);
        wait_all_results();

        // Largest gains: the adjustment saturates the clamp almost every time.
        set_gains(12'd4095, 12'd4095, 12'd4095);
        run_random(100);
        wait_all_results();

        // Small gains keep speeds close to the base, where the deadzone matters.
        set_gains(12'd16, 12'd1, 12'd8);
        run_random(100);
        wait_all_results();

        set_gains(12'd1, 12'd0, 12'd4095);
        run_random(100);
        wait_all_results();

        repeat (2) begin
            set_gains(GAIN_W'($urandom_range(0, 4095)), GAIN_W'($urandom_range(0, 63)),
                      GAIN_W'($urandom_range(0, 4095)));
            hold_off_req = ($urandom_range(0, 1) == 1);
            run_random(100);
            wait_all_results();
        end

        // Integral build-up. With only the integral gain at its smallest value the
        // speeds follow the running sum. The sum climbs under large positive offsets,
        // is walked down by moderate negative offsets, and then climbs back, all
        // without the hard-turn overrides.
        set_gains(12'd0, 12'd1, 12'd0);
        run_offset_span(60, 200, 255);
        run_offset_span(150, -63, -40);
        run_offset_span(60, 40, 63);
        wait_all_results();

        set_gains(GAIN_PROP_RST, GAIN_INTEG_RST, GAIN_DERIV_RST);
        run_random(100);
        wait_all_results();

        if (speeds.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/lfpd_pkg.sv
rtl/lfpd_mult.sv
rtl/line_follow_pid_drive.sv
tb/line_follow_pid_drive_test.sv
